/* sv/srpc_pkg.sv */
// Shared constants and types for the square-root position controller.
`timescale 1ns / 1ps

package srpc_pkg;

    localparam int ERROR_WIDTH_DEFAULT = 24;

    localparam int GAIN_WIDTH  = 16;
    localparam int LIMIT_WIDTH = 16;
    localparam int LIMIT_MAG_W = LIMIT_WIDTH - 1;
    localparam int GAIN_FRAC   = 12;
    localparam int KNEE_SHIFT  = 24;

    // Gain squared, and the dividends of the knee and offset divisions.
    localparam int G2_W      = 2 * GAIN_WIDTH;
    localparam int LIM2_W    = 2 * LIMIT_MAG_W;
    localparam int DIV_W     = LIM2_W + KNEE_SHIFT;
    localparam int KNEE_W    = LIMIT_MAG_W + KNEE_SHIFT;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN        = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_LIMIT = 1'b1;

    localparam logic [GAIN_WIDTH-1:0]         GAIN_RESET  = 16'd410;
    localparam logic signed [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'sd64;

    typedef enum logic [1:0] {
        SEQ_SQUARE,
        SEQ_KNEE,
        SEQ_SUB,
        SEQ_READY
    } seq_state_t;

endpackage

/* sv/square_root_position_controller.sv */
// Square-root position controller: linear law with square-root shaping, fully pipelined.
`timescale 1ns / 1ps

// Takes one error item per cycle and returns one command item per cycle while
// in_ready and out_ready are high. An item passes stages A to D, the square-root
// stages, stage E and the output register; the square-root pipeline resolves
// one root bit per stage. Stages that hold no item keep accepting while a result
// waits at the output. After reset and after every configuration write, in_ready
// stays low while a shared bit-serial divider forms the knee point and the curve
// offset from gain and accel_limit, one quotient bit per cycle.
module square_root_position_controller #(
    parameter int ERROR_WIDTH = srpc_pkg::ERROR_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [srpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [srpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ERROR_WIDTH-1:0]       error,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ERROR_WIDTH-1:0]       command,
    output logic                                saturated
);
    import srpc_pkg::*;

    localparam int W      = ERROR_WIDTH;
    localparam int HALF   = (W + 1) / 2;
    localparam int HI_W   = W - HALF;
    localparam int LP_W   = W + GAIN_WIDTH;
    localparam int LIN_W  = LP_W - GAIN_FRAC;
    localparam int RW     = W + LIMIT_WIDTH - 1;
    localparam int CP_W   = RW - 1;
    localparam int Q      = (RW + 1) / 2;
    localparam int RAD_W  = 2 * Q;
    localparam int CMP_W  = (W > KNEE_W) ? W : KNEE_W;
    localparam int SUBX_W = (RW > DIV_W) ? RW : DIV_W;

    localparam int PG_LO_W = GAIN_WIDTH + HALF;
    localparam int PG_HI_W = GAIN_WIDTH + HI_W;
    localparam int PL_LO_W = LIMIT_MAG_W + HALF;
    localparam int PL_HI_W = LIMIT_MAG_W + HI_W;

    localparam logic [LP_W-1:0]  ROUND_HALF = LP_W'(1) << (GAIN_FRAC - 1);
    localparam logic [LIN_W-1:0] NEG_MAX    = LIN_W'(1) << (W - 1);
    localparam logic [LIN_W-1:0] POS_MAX    = NEG_MAX - LIN_W'(1);
    localparam logic [W-1:0]     CMD_MAX    = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0]     CMD_MIN    = {1'b1, {(W - 1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_WIDTH-1:0]         gain_reg;
    logic signed [LIMIT_WIDTH-1:0] limit_reg;
    logic [LIMIT_MAG_W-1:0]        lim_mag;
    logic                          curve_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN:        gain_reg  <= cfg_data[GAIN_WIDTH-1:0];
                REG_ACCEL_LIMIT: limit_reg <= cfg_data[LIMIT_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    assign lim_mag  = limit_reg[LIMIT_MAG_W-1:0];
    assign curve_en = !limit_reg[LIMIT_WIDTH-1] && (limit_reg != '0) && (gain_reg != '0);

    // ------------------------------------------------------------------
    // Knee and offset sequencer with a restoring divider
    // ------------------------------------------------------------------
    seq_state_t            seq_state_reg, seq_state_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [G2_W-1:0]       div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]      div_quo_reg, div_quo_next;
    logic [G2_W-1:0]       g2_reg, g2_next;
    logic [LIM2_W-1:0]     lim2_reg, lim2_next;
    logic [KNEE_W-1:0]     knee_reg, knee_next;
    logic [DIV_W-1:0]      sub_reg, sub_next;

    logic [G2_W:0]         rem_sh;
    logic [G2_W:0]         rem_dif;
    logic                  div_ge;
    logic [G2_W-1:0]       step_rem;
    logic [DIV_W-1:0]      step_quo;
    logic                  last_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SEQ_SQUARE;
            div_cnt_reg   <= '0;
        end
        else
        begin
            seq_state_reg <= seq_state_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        g2_reg      <= g2_next;
        lim2_reg    <= lim2_next;
        knee_reg    <= knee_next;
        sub_reg     <= sub_next;
    end

    always_comb
    begin
        seq_state_next = seq_state_reg;
        div_cnt_next   = div_cnt_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        g2_next        = g2_reg;
        lim2_next      = lim2_reg;
        knee_next      = knee_reg;
        sub_next       = sub_reg;

        rem_sh    = {div_rem_reg, div_quo_reg[DIV_W-1]};
        rem_dif   = rem_sh - {1'b0, g2_reg};
        div_ge    = rem_sh >= {1'b0, g2_reg};
        step_rem  = div_ge ? rem_dif[G2_W-1:0] : rem_sh[G2_W-1:0];
        step_quo  = {div_quo_reg[DIV_W-2:0], div_ge};
        last_step = div_cnt_reg == DIV_CNT_W'(DIV_W - 1);

        case (seq_state_reg)
            SEQ_SQUARE:
            begin
                g2_next        = G2_W'(gain_reg) * G2_W'(gain_reg);
                lim2_next      = LIM2_W'(lim_mag) * LIM2_W'(lim_mag);
                div_rem_next   = '0;
                div_quo_next   = DIV_W'({lim_mag, {KNEE_SHIFT{1'b0}}});
                div_cnt_next   = '0;
                seq_state_next = SEQ_KNEE;
            end
            SEQ_KNEE:
            begin
                div_rem_next = step_rem;
                div_quo_next = step_quo;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (last_step)
                begin
                    knee_next      = step_quo[KNEE_W-1:0];
                    div_rem_next   = '0;
                    div_quo_next   = {lim2_reg, {KNEE_SHIFT{1'b0}}};
                    div_cnt_next   = '0;
                    seq_state_next = SEQ_SUB;
                end
            end
            SEQ_SUB:
            begin
                div_rem_next = step_rem;
                div_quo_next = step_quo;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (last_step)
                begin
                    sub_next       = step_quo;
                    div_cnt_next   = '0;
                    seq_state_next = SEQ_READY;
                end
            end
            SEQ_READY:
            begin
            end
            default:
            begin
                seq_state_next = SEQ_SQUARE;
            end
        endcase

        // Any register write invalidates the knee and offset.
        if (cfg_write)
        begin
            seq_state_next = SEQ_SQUARE;
        end
    end

    // ------------------------------------------------------------------
    // Item pipeline: stage enables
    // ------------------------------------------------------------------
    logic         en_a, en_b, en_c, en_d, en_e, en_out;
    logic         en_sq [Q];

    logic         a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, out_valid_reg;
    logic         sq_v_reg [Q];

    always_comb
    begin
        en_out        = !out_valid_reg || out_ready;
        en_e          = !e_v_reg || en_out;
        en_sq[Q-1]    = !sq_v_reg[Q-1] || en_e;
        for (int k = Q - 2; k >= 0; k--)
        begin
            en_sq[k] = !sq_v_reg[k] || en_sq[k+1];
        end
        en_d = !d_v_reg || en_sq[0];
        en_c = !c_v_reg || en_d;
        en_b = !b_v_reg || en_c;
        en_a = !a_v_reg || en_b;
    end

    assign in_ready = en_a && (seq_state_reg == SEQ_READY);

    // ------------------------------------------------------------------
    // Stage A: sign and magnitude
    // ------------------------------------------------------------------
    logic [W-1:0] err_raw;
    logic [W-1:0] in_mag;
    logic         a_neg_reg;
    logic [W-1:0] a_mag_reg;

    // The most negative error keeps its magnitude 2^(W-1) as an unsigned value.
    assign err_raw = error;
    assign in_mag  = err_raw[W-1] ? (~err_raw + W'(1)) : err_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (en_a)
        begin
            a_v_reg <= in_valid && in_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_neg_reg <= err_raw[W-1];
            a_mag_reg <= in_mag;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: knee compare and partial products
    // ------------------------------------------------------------------
    logic               b_neg_reg, b_curve_reg;
    logic [PG_LO_W-1:0] b_pg_lo_reg;
    logic [PG_HI_W-1:0] b_pg_hi_reg;
    logic [PL_LO_W-1:0] b_pl_lo_reg;
    logic [PL_HI_W-1:0] b_pl_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (en_b)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            b_neg_reg   <= a_neg_reg;
            b_curve_reg <= curve_en && (CMP_W'(a_mag_reg) > CMP_W'(knee_reg));
            b_pg_lo_reg <= PG_LO_W'(gain_reg) * PG_LO_W'(a_mag_reg[HALF-1:0]);
            b_pg_hi_reg <= PG_HI_W'(gain_reg) * PG_HI_W'(a_mag_reg[W-1:HALF]);
            b_pl_lo_reg <= PL_LO_W'(lim_mag) * PL_LO_W'(a_mag_reg[HALF-1:0]);
            b_pl_hi_reg <= PL_HI_W'(lim_mag) * PL_HI_W'(a_mag_reg[W-1:HALF]);
        end
    end

    // ------------------------------------------------------------------
    // Stage C: full products
    // ------------------------------------------------------------------
    logic            c_neg_reg, c_curve_reg;
    logic [LP_W-1:0] c_lin_prod_reg;
    logic [CP_W-1:0] c_cprod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (en_c)
        begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_neg_reg      <= b_neg_reg;
            c_curve_reg    <= b_curve_reg;
            c_lin_prod_reg <= LP_W'({b_pg_hi_reg, {HALF{1'b0}}}) + LP_W'(b_pg_lo_reg);
            c_cprod_reg    <= CP_W'({b_pl_hi_reg, {HALF{1'b0}}}) + CP_W'(b_pl_lo_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage D: rounded linear law and radicand
    // ------------------------------------------------------------------
    logic              d_neg_reg, d_curve_reg;
    logic [LIN_W-1:0]  d_lin_reg;
    logic [RAD_W-1:0]  d_rad_reg;
    logic [LP_W-1:0]   lin_round;
    logic [SUBX_W-1:0] sub_wide;
    logic [RW-1:0]     rad_val;

    // The radicand is formed modulo 2^RW; it is exact wherever the curve applies.
    assign lin_round = c_lin_prod_reg + ROUND_HALF;
    assign sub_wide  = SUBX_W'(sub_reg);
    assign rad_val   = {c_cprod_reg, 1'b0} - sub_wide[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
        end
        else if (en_d)
        begin
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            d_neg_reg   <= c_neg_reg;
            d_curve_reg <= c_curve_reg;
            d_lin_reg   <= lin_round[LP_W-1:GAIN_FRAC];
            d_rad_reg   <= RAD_W'(rad_val);
        end
    end

    // ------------------------------------------------------------------
    // Square-root pipeline, one root bit per stage
    // ------------------------------------------------------------------
    logic             sq_neg_reg   [Q];
    logic             sq_curve_reg [Q];
    logic [LIN_W-1:0] sq_lin_reg   [Q];
    logic [RAD_W-1:0] sq_rad_reg   [Q];
    logic [Q-1:0]     sq_rem_reg   [Q];
    logic [Q-1:0]     sq_root_reg  [Q];

    for (genvar i = 0; i < Q; i++)
    begin : g_sqrt
        logic             st_v, st_neg, st_curve;
        logic [LIN_W-1:0] st_lin;
        logic [RAD_W-1:0] st_rad;
        logic [Q-1:0]     st_rem, st_root;
        logic [Q+1:0]     st_sh, st_trial, st_dif;
        logic             st_ge;

        if (i == 0)
        begin : g_first
            assign st_v     = d_v_reg;
            assign st_neg   = d_neg_reg;
            assign st_curve = d_curve_reg;
            assign st_lin   = d_lin_reg;
            assign st_rad   = d_rad_reg;
            assign st_rem   = '0;
            assign st_root  = '0;
        end
        else
        begin : g_follow
            assign st_v     = sq_v_reg[i-1];
            assign st_neg   = sq_neg_reg[i-1];
            assign st_curve = sq_curve_reg[i-1];
            assign st_lin   = sq_lin_reg[i-1];
            assign st_rad   = sq_rad_reg[i-1];
            assign st_rem   = sq_rem_reg[i-1];
            assign st_root  = sq_root_reg[i-1];
        end

        // Until the last stage the partial remainder stays below 2^Q.
        assign st_sh    = {st_rem, st_rad[RAD_W-1 -: 2]};
        assign st_trial = {st_root, 2'b01};
        assign st_ge    = st_sh >= st_trial;
        assign st_dif   = st_sh - st_trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[i] <= 1'b0;
            end
            else if (en_sq[i])
            begin
                sq_v_reg[i] <= st_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en_sq[i])
            begin
                sq_neg_reg[i]   <= st_neg;
                sq_curve_reg[i] <= st_curve;
                sq_lin_reg[i]   <= st_lin;
                sq_rad_reg[i]   <= {st_rad[RAD_W-3:0], 2'b00};
                sq_rem_reg[i]   <= st_ge ? st_dif[Q-1:0] : st_sh[Q-1:0];
                sq_root_reg[i]  <= {st_root[Q-2:0], st_ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage E: law select and clamp
    // ------------------------------------------------------------------
    logic             e_neg_reg, e_sat_reg;
    logic [W-1:0]     e_mag_reg;
    logic [LIN_W-1:0] sel_m;
    logic [LIN_W-1:0] sel_lim;
    logic             sel_sat;

    assign sel_m   = sq_curve_reg[Q-1] ? LIN_W'(sq_root_reg[Q-1]) : sq_lin_reg[Q-1];
    assign sel_lim = sq_neg_reg[Q-1] ? NEG_MAX : POS_MAX;
    assign sel_sat = sel_m > sel_lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else if (en_e)
        begin
            e_v_reg <= sq_v_reg[Q-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            e_neg_reg <= sq_neg_reg[Q-1];
            e_sat_reg <= sel_sat;
            e_mag_reg <= sel_sat ? sel_lim[W-1:0] : sel_m[W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register: apply sign
    // ------------------------------------------------------------------
    logic [W-1:0] command_reg;
    logic         saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= e_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            command_reg   <= e_neg_reg ? (~e_mag_reg + W'(1)) : e_mag_reg;
            saturated_reg <= e_sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign command   = command_reg;
    assign saturated = saturated_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_after_tables: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (seq_state_reg == SEQ_READY))
        else $error("in_ready high before knee and offset are ready");

    a_write_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !in_ready)
        else $error("input accepted right after a register write");

    a_curve_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        b_v_reg && b_curve_reg |-> curve_en)
        else $error("curve law chosen with zero gain or non-positive limit");

    a_saturated_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (command_reg == CMD_MAX || command_reg == CMD_MIN))
        else $error("saturated item not at an output rail");

endmodule

/* tb/tb.sv */
// Testbench for the square-root position controller: random and directed errors, checked per item.
`timescale 1ns / 1ps

module tb;

    import srpc_pkg::*;

    localparam int EW          = ERROR_WIDTH_DEFAULT;
    localparam int PIPE_DEPTH  = (EW + 16) / 2 + 6;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [EW-1:0] ERR_MAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] ERR_MIN = {1'b1, {(EW-1){1'b0}}};

    typedef struct packed {
        logic [EW-1:0] command;
        logic          saturated;
    } cmd_item_t;

    // Holds a copy of the two registers and the commands still owed by the block.
    class shaping_checker;
        logic [GAIN_WIDTH-1:0]         gain_q;
        logic signed [LIMIT_WIDTH-1:0] limit_q;
        cmd_item_t                     expected_commands[$];
        int                            errors;

        function new();
            gain_q  = GAIN_RESET;
            limit_q = LIMIT_RESET;
            errors  = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_GAIN:        gain_q = val;
                REG_ACCEL_LIMIT: limit_q = val;
                default:         ;
            endcase
        endfunction

        function bit curve_enabled();
            return (gain_q != 0) && (limit_q > 0);
        endfunction

        // Error magnitude above which the square-root law takes over.
        function longint unsigned knee_point();
            longint unsigned g;
            longint unsigned l;
            if (!curve_enabled())
                return 0;
            g = gain_q;
            l = limit_q;
            return (l << KNEE_SHIFT) / (g * g);
        endfunction

        function longint unsigned root_floor(longint unsigned r);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= r)
                    root = trial;
            end
            return root;
        endfunction

        function void note_error(logic [EW-1:0] e);
            cmd_item_t       item;
            longint unsigned half;
            longint unsigned mag;
            longint unsigned g;
            longint unsigned l;
            longint unsigned m;
            bit              neg;
            half = 64'd1 << (EW - 1);
            neg  = e[EW-1];
            mag  = neg ? ((64'd1 << EW) - 64'(e)) : 64'(e);
            g    = gain_q;
            if (curve_enabled() && mag > knee_point()) begin
                l = limit_q;
                m = root_floor(2 * l * mag - (((l * l) << KNEE_SHIFT) / (g * g)));
            end else begin
                m = (mag * g + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
            end
            item.saturated = 1'b0;
            if (neg && m > half) begin
                m = half;
                item.saturated = 1'b1;
            end else if (!neg && m > half - 1) begin
                m = half - 1;
                item.saturated = 1'b1;
            end
            item.command = neg ? EW'(-m) : EW'(m);
            expected_commands = {expected_commands, item};
        endfunction

        function void check_command(logic [EW-1:0] cmd, logic sat);
            cmd_item_t want;
            if (expected_commands.size() == 0) begin
                $display("%0t: command %0d arrived with no item outstanding",
                         $time, $signed(cmd));
                errors++;
                return;
            end
            want = expected_commands.pop_front();
            if (cmd !== want.command) begin
                $display("%0t: command mismatch: expected %0d, actual %0d",
                         $time, $signed(want.command), $signed(cmd));
                errors++;
            end
            if (sat !== want.saturated) begin
                $display("%0t: saturated mismatch: expected %0b, actual %0b",
                         $time, want.saturated, sat);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_GAIN;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [EW-1:0]          err_sample = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [EW-1:0]          command;
    logic                   saturated;

    shaping_checker sb;
    bit             calm = 1'b0;
    int             cycles = 0;

    square_root_position_controller #(
        .ERROR_WIDTH(EW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .error     (err_sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .command   (command),
        .saturated (saturated)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: values read right after the edge are the ones the edge sampled.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_command(command, saturated);
            out_ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    task automatic send_error(logic [EW-1:0] e);
        while (!calm && $urandom_range(0, 99) < 16) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        err_sample <= e;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_error(e);
    endtask

    task automatic end_phase();
        in_valid <= 1'b0;
        while (sb.expected_commands.size() != 0)
            @(posedge clk);
    endtask

    // Writes both registers on consecutive edges while the block is idle.
    task automatic set_config(logic [CFG_DATA_W-1:0] g, logic [CFG_DATA_W-1:0] l);
        cfg_write <= 1'b1;
        cfg_index <= REG_GAIN;
        cfg_data  <= g;
        @(posedge clk);
        cfg_index <= REG_ACCEL_LIMIT;
        cfg_data  <= l;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(REG_GAIN, g);
        sb.set_reg(REG_ACCEL_LIMIT, l);
    endtask

    // Mix of full-range values, values around the knee, small values and extremes.
    function automatic logic [EW-1:0] pick_error();
        longint          m;
        longint          k;
        longint unsigned top;
        int              sel;
        bit              neg;
        sel = $urandom_range(0, 99);
        top = 64'd1 << (EW - 1);
        neg = 1'($urandom_range(0, 1));
        if (sel < 30)
            return EW'($urandom);
        if (sel < 55) begin
            k = sb.knee_point();
            if (k > top)
                k = top;
            m = k + $urandom_range(0, 16) - 8;
            if (m < 0)
                m = -m;
        end else if (sel < 85) begin
            m = longint'($urandom_range(0, 4095)) << $urandom_range(0, 11);
        end else begin
            case ($urandom_range(0, 2))
                0:       m = 0;
                1:       m = 1;
                default: m = top;
            endcase
        end
        if (m > top)
            m = top;
        if (!neg && m == top)
            m = top - 1;
        return neg ? EW'(-m) : EW'(m);
    endfunction

    initial
    begin
        longint unsigned        k;
        logic [CFG_DATA_W-1:0]  g;
        logic [CFG_DATA_W-1:0]  l;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: zero, unit steps, the range ends, and both sides of the knee.
        k = sb.knee_point();
        send_error('0);
        send_error(EW'(1));
        send_error(EW'(-1));
        send_error(ERR_MAX);
        send_error(ERR_MIN);
        send_error(EW'(k));
        send_error(EW'(k + 1));
        send_error(EW'(-k));
        send_error(EW'(-(k + 1)));
        end_phase();

        // Unity gain, linear: the most negative error just fits without clipping.
        set_config(16'd4096, 16'h0000);
        send_error(EW'(1));
        send_error(EW'(-1));
        send_error(ERR_MAX);
        send_error(ERR_MIN);
        end_phase();

        // Gain just above unity with a negative limit clips both ways.
        set_config(16'd4097, 16'h8000);
        send_error(ERR_MIN);
        send_error(ERR_MAX);
        end_phase();

        // Zero gain forces the linear law even with a positive limit.
        set_config(16'h0000, 16'h7FFF);
        send_error(ERR_MAX);
        send_error(ERR_MIN);
        end_phase();

        set_config(16'hFFFF, 16'h7FFF);
        k = sb.knee_point();
        send_error(EW'(k));
        send_error(EW'(k + 1));
        send_error(EW'(-(k + 1)));
        send_error(ERR_MAX);
        end_phase();

        for (int ph = 0; ph < 11; ph++) begin
            case (ph)
                0: set_config(16'hFFFF, 16'h7FFF);
                1: set_config(16'h0001, 16'h0001);
                2: set_config(16'h0000, 16'h0064);
                3: set_config(16'h1000, 16'hFFFF);
                4: set_config(16'hFFFF, 16'h8000);
                default: begin
                    g = CFG_DATA_W'($urandom);
                    l = CFG_DATA_W'($urandom);
                    if ($urandom_range(0, 2) != 0)
                        l[CFG_DATA_W-1] = 1'b0;
                    set_config(g, l);
                end
            endcase
            calm = (ph == 5 || ph == 6);
            repeat (50) send_error(pick_error());
            end_phase();
        end
        calm = 1'b0;

        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (sb.expected_commands.size() != 0) begin
            $display("%0t: %0d commands never arrived", $time, sb.expected_commands.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* square_root_position_controller.f */
sv/srpc_pkg.sv
sv/square_root_position_controller.sv
tb/tb.sv
